// ----- hdl/trag_pkg.sv -----
// Shared types and constants of the tensor roll address generator.
package trag_pkg;

  localparam int COUNT_BITS     = 32;
  localparam int VALUE_BITS     = 64;
  localparam int DEST_BITS      = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTER = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INNER = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SHIFT = 2'd3;

  // Effective configuration: counts already forced to at least one.
  typedef struct packed {
    logic [COUNT_BITS-1:0] outer;
    logic [COUNT_BITS-1:0] axis;
    logic [COUNT_BITS-1:0] inner;
    logic [COUNT_BITS-1:0] shift;
  } trag_cfg_t;

  // Position and wrap flags of one item, worked out by the front end.
  typedef struct packed {
    logic [COUNT_BITS-1:0] k;
    logic [COUNT_BITS-1:0] i;
    logic                  start;
    logic                  inner_wrap;
    logic                  axis_wrap;
    logic                  last;
  } trag_tag_t;

endpackage

// ----- hdl/tensor_roll_address_generator.sv -----
// Top level of the tensor roll address generator: config registers, front, queue, back.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------
//   input    | in_valid / in_ready     | element_value
//   output   | out_valid / out_ready   | element_out, dest_index, last_element
//   config   | cfg_we (no wait)        | cfg_index, cfg_data
//
// An element passes through the back end in steps: issue, row-offset multiply, index sum.
// The first element of a run, and the first after a config write, also wait on
// the serial remainder divider that reduces the shift; after a config write the
// stride multiply comes first. Reset is synchronous and restores counts of 1
// and a zero shift. A two-entry queue keeps the input taking items while the back
// end works, and the output register holds a result until it is taken.
module tensor_roll_address_generator import trag_pkg::*; #(
  parameter int INDEX_BITS   = 32,
  parameter int ELEMENT_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COUNT_BITS-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [VALUE_BITS-1:0]     element_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [VALUE_BITS-1:0]     element_out,
  output logic [DEST_BITS-1:0]      dest_index,
  output logic                      last_element
);

  localparam int ENTRY_BITS = $bits(trag_tag_t) + ELEMENT_BITS;

  logic [COUNT_BITS-1:0]   outer_count;
  logic [COUNT_BITS-1:0]   axis_length;
  logic [COUNT_BITS-1:0]   inner_count;
  logic [COUNT_BITS-1:0]   shift_amount;
  trag_cfg_t               cfg;
  trag_tag_t               front_tag;
  trag_tag_t               q_tag;
  logic [ELEMENT_BITS-1:0] q_elem;
  logic [ENTRY_BITS-1:0]   q_out;
  logic                    q_full;
  logic                    q_empty;
  logic                    q_ready;
  logic                    accept;
  logic [ELEMENT_BITS-1:0] out_elem;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_count  <= 32'd1;
      axis_length  <= 32'd1;
      inner_count  <= 32'd1;
      shift_amount <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUTER: outer_count  <= cfg_data;
        CFG_AXIS:  axis_length  <= cfg_data;
        CFG_INNER: inner_count  <= cfg_data;
        CFG_SHIFT: shift_amount <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero count behaves as one.
  always_comb begin
    cfg.outer = (outer_count == '0) ? 32'd1 : outer_count;
    cfg.axis  = (axis_length == '0) ? 32'd1 : axis_length;
    cfg.inner = (inner_count == '0) ? 32'd1 : inner_count;
    cfg.shift = shift_amount;
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  trag_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .tag    (front_tag)
  );

  trag_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({front_tag, element_value[ELEMENT_BITS-1:0]}),
    .full      (q_full),
    .pop       (q_ready),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  assign q_tag  = q_out[ENTRY_BITS-1:ELEMENT_BITS];
  assign q_elem = q_out[ELEMENT_BITS-1:0];

  trag_back #(
    .INDEX_BITS   (INDEX_BITS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_we    (cfg_we),
    .q_valid   (!q_empty),
    .q_ready   (q_ready),
    .q_tag     (q_tag),
    .q_elem    (q_elem),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_elem  (out_elem),
    .out_dest  (dest_index),
    .out_last  (last_element)
  );

  assign element_out = VALUE_BITS'(out_elem);

endmodule

// ----- hdl/trag_front.sv -----
// Front end: tracks the source position of each item and classifies its wraps.
module trag_front import trag_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  trag_cfg_t cfg,
  input  logic      accept,
  output trag_tag_t tag
);

  logic [COUNT_BITS-1:0] inner_pos;
  logic [COUNT_BITS-1:0] axis_pos;
  logic [COUNT_BITS-1:0] block_pos;
  logic                  inner_end;
  logic                  axis_end;
  logic                  block_end;

  // A position at or past the last one of its range counts as its end.
  assign inner_end = ({1'b0, inner_pos} + 33'd1) >= {1'b0, cfg.inner};
  assign axis_end  = ({1'b0, axis_pos} + 33'd1) >= {1'b0, cfg.axis};
  assign block_end = ({1'b0, block_pos} + 33'd1) >= {1'b0, cfg.outer};

  always_comb begin
    tag.k          = axis_pos;
    tag.i          = inner_pos;
    tag.start      = (inner_pos == '0) && (axis_pos == '0) && (block_pos == '0);
    tag.inner_wrap = inner_end;
    tag.axis_wrap  = inner_end && axis_end;
    tag.last       = inner_end && axis_end && block_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_pos <= '0;
      axis_pos  <= '0;
      block_pos <= '0;
    end else if (accept) begin
      if (!inner_end) begin
        inner_pos <= inner_pos + 32'd1;
      end else begin
        inner_pos <= '0;
        if (!axis_end) begin
          axis_pos <= axis_pos + 32'd1;
        end else begin
          axis_pos <= '0;
          if (!block_end) begin
            block_pos <= block_pos + 32'd1;
          end else begin
            block_pos <= '0;
          end
        end
      end
    end
  end

endmodule

// ----- hdl/trag_queue.sv -----
// Short queue of classified items between the front and back ends.
module trag_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign full     = (fill == CNT_BITS'(DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_BITS'(1);
      end
    end
  end

endmodule

// ----- hdl/trag_div.sv -----
// Serial restoring divider that returns the remainder, one bit a cycle.
module trag_div import trag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [COUNT_BITS-1:0] remainder
);

  localparam int STEPS     = COUNT_BITS + 1;
  localparam int STEP_BITS = $clog2(STEPS + 1);

  logic [COUNT_BITS:0]   dvd;
  logic [COUNT_BITS:0]   rem;
  logic [COUNT_BITS-1:0] dsr;
  logic [STEP_BITS-1:0]  steps_left;
  logic                  running;
  logic [COUNT_BITS:0]   rem_shifted;
  logic [COUNT_BITS:0]   rem_next;

  // The remainder stays below the divisor, so its top bit is always clear.
  assign rem_shifted = {rem[COUNT_BITS-1:0], dvd[COUNT_BITS]};
  assign rem_next    = (rem_shifted >= {1'b0, dsr}) ? rem_shifted - {1'b0, dsr}
                                                    : rem_shifted;
  assign remainder   = rem[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= !start && running && (steps_left == STEP_BITS'(1));
      if (start) begin
        running    <= 1'b1;
        steps_left <= STEP_BITS'(STEPS);
      end else if (running) begin
        steps_left <= steps_left - STEP_BITS'(1);
        if (steps_left == STEP_BITS'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[COUNT_BITS-1:0], 1'b0};
      rem <= rem_next;
    end
  end

endmodule

// ----- hdl/trag_back.sv -----
// Back end: rolled axis position, destination index and the output register.
module trag_back import trag_pkg::*; #(
  parameter int INDEX_BITS   = 32,
  parameter int ELEMENT_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  trag_cfg_t               cfg,
  input  logic                    cfg_we,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  trag_tag_t               q_tag,
  input  logic [ELEMENT_BITS-1:0] q_elem,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ELEMENT_BITS-1:0] out_elem,
  output logic [DEST_BITS-1:0]    out_dest,
  output logic                    out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_STRIDE,
    S_DIV,
    S_SUM
  } state_t;

  state_t                  state;
  trag_tag_t               tag;
  logic [ELEMENT_BITS-1:0] elem;
  logic [COUNT_BITS-1:0]   rolled;
  logic [COUNT_BITS-1:0]   red_shift;
  logic [INDEX_BITS-1:0]   block_base;
  logic [INDEX_BITS-1:0]   stride;
  logic [INDEX_BITS-1:0]   row_offset;
  logic                    stride_stale;
  logic                    resync;
  logic                    need_div;

  logic [COUNT_BITS-1:0]   mul_x;
  logic [2*COUNT_BITS-1:0] product;
  logic                    div_start;
  logic                    div_done;
  logic [COUNT_BITS-1:0]   div_rem;
  logic [COUNT_BITS-1:0]   shift_mag;
  logic [COUNT_BITS:0]     div_dividend;
  logic [COUNT_BITS-1:0]   div_result;
  logic [INDEX_BITS-1:0]   dest_sum;
  logic                    rolled_end;
  logic                    out_free;

  // One shared multiplier: axis times inner for the block stride, else row offset.
  assign mul_x   = (state == S_STRIDE) ? cfg.axis : rolled;
  assign product = (2*COUNT_BITS)'(mul_x) * (2*COUNT_BITS)'(cfg.inner);

  assign shift_mag    = cfg.shift[COUNT_BITS-1] ? (32'd0 - cfg.shift) : cfg.shift;
  assign div_dividend = tag.start ? {1'b0, shift_mag} : ({1'b0, tag.k} + {1'b0, red_shift});
  assign div_start    = (state == S_PREP) && !stride_stale && need_div;

  // Euclidean fix-up of a negative shift.
  assign div_result = (tag.start && cfg.shift[COUNT_BITS-1] && (div_rem != '0))
                      ? cfg.axis - div_rem : div_rem;

  assign dest_sum   = block_base + row_offset + INDEX_BITS'(tag.i);
  assign rolled_end = ({1'b0, rolled} + 33'd1) == {1'b0, cfg.axis};
  assign out_free   = !out_valid || out_ready;
  assign q_ready    = (state == S_IDLE);

  trag_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (cfg.axis),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      stride_stale <= 1'b1;
      resync       <= 1'b0;
      need_div     <= 1'b0;
      rolled       <= '0;
      red_shift    <= '0;
      block_base   <= '0;
    end else begin
      // Drop a taken result unless a new one replaces it this cycle.
      if (out_valid && out_ready && (state != S_SUM)) begin
        out_valid <= 1'b0;
      end
      // Any config write invalidates the stride and the rolled position.
      if (cfg_we) begin
        stride_stale <= 1'b1;
        resync       <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            tag      <= q_tag;
            elem     <= q_elem;
            need_div <= q_tag.start || resync;
            if (q_tag.start) begin
              block_base <= '0;
            end
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (stride_stale) begin
            state <= S_STRIDE;
          end else if (need_div) begin
            state <= S_DIV;
          end else begin
            row_offset <= product[INDEX_BITS-1:0];
            state      <= S_SUM;
          end
        end
        S_STRIDE: begin
          stride       <= product[INDEX_BITS-1:0];
          stride_stale <= 1'b0;
          state        <= S_PREP;
        end
        S_DIV: begin
          if (div_done) begin
            rolled   <= div_result;
            need_div <= 1'b0;
            resync   <= 1'b0;
            if (tag.start) begin
              red_shift <= div_result;
            end
            state <= S_PREP;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_elem  <= elem;
            out_dest  <= DEST_BITS'(dest_sum);
            out_last  <= tag.last;
            if (tag.axis_wrap) begin
              rolled <= red_shift;
              resync <= (red_shift >= cfg.axis);
              block_base <= tag.last ? '0 : block_base + stride;
            end else if (tag.inner_wrap) begin
              rolled <= rolled_end ? '0 : rolled + 32'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
